FILE: rtl/core/eba_pkg.sv
// shared operation codes and item structures for the eight-bit alu
package eba_pkg;

   typedef enum logic [3:0] {
      OP_ADC          = 4'd0,
      OP_SBC          = 4'd1,
      OP_AND          = 4'd2,
      OP_ORA          = 4'd3,
      OP_EOR          = 4'd4,
      OP_ASL          = 4'd5,
      OP_LSR          = 4'd6,
      OP_ROL          = 4'd7,
      OP_ROR          = 4'd8,
      OP_INC          = 4'd9,
      OP_DEC          = 4'd10,
      OP_CMP          = 4'd11,
      OP_BIT          = 4'd12,
      OP_LOAD_FLAGS   = 4'd13,
      OP_LOAD_NOFLAGS = 4'd14
   } op_type;

   typedef struct packed {
      logic [3:0] op;
      logic [7:0] reg_operand;
      logic [7:0] mem_operand;
      logic       carry_in;
      logic       overflow_in;
      logic       negative_in;
      logic       zero_in;
      logic       decimal_mode;
   } req_item_type;

   typedef struct packed {
      logic [7:0] result;
      logic       negative_out;
      logic       zero_out;
      logic       carry_out;
      logic       overflow_out;
   } rsp_item_type;

endpackage

FILE: rtl/core/eba_alu.sv
// combinational datapath: binary and bcd arithmetic, logic, shifts and flag update
module eba_alu
   import eba_pkg::*;
(
   input  req_item_type item,
   output rsp_item_type res
);

   logic [7:0] a;
   logic [7:0] m;
   logic       c;
   logic [7:0] r;
   logic       n;
   logic       z;
   logic       c_out;
   logic       v;
   logic       nz_from_r;
   logic [8:0] add_bin;
   logic [8:0] sub_bin;
   logic [5:0] dadd_lo;
   logic [5:0] dadd_hi;
   logic [4:0] dsub_lo;
   logic [4:0] dsub_hi;
   logic [3:0] dsub_lo_fix;
   logic [3:0] dsub_hi_fix;
   logic [7:0] cmp_diff;

   assign a = item.reg_operand;
   assign m = item.mem_operand;
   assign c = item.carry_in;

   assign add_bin = {1'b0, a} + {1'b0, m} + {8'd0, c};
   assign sub_bin = {1'b0, a} + {1'b0, ~m} + {8'd0, c};
   assign cmp_diff = a - m;

   // bcd add, one digit at a time
   always_comb begin
      dadd_lo = {2'b00, a[3:0]} + {2'b00, m[3:0]} + {5'd0, c};
      if (dadd_lo > 6'd9) begin
         dadd_lo = dadd_lo + 6'd6;
      end
      dadd_hi = {2'b00, a[7:4]} + {2'b00, m[7:4]} + {5'd0, (dadd_lo > 6'd15)};
      if (dadd_hi > 6'd9) begin
         dadd_hi = dadd_hi + 6'd6;
      end
   end

   // bcd subtract, borrowing digits corrected by six
   always_comb begin
      dsub_lo = {1'b0, a[3:0]} + 5'd16 - {1'b0, m[3:0]} - {4'd0, ~c};
      dsub_hi = {1'b0, a[7:4]} + 5'd16 - {1'b0, m[7:4]};
      if (!dsub_lo[4]) begin
         dsub_lo_fix = dsub_lo[3:0] - 4'd6;
         dsub_hi = dsub_hi - 5'd1;
      end else begin
         dsub_lo_fix = dsub_lo[3:0];
      end
      if (!dsub_hi[4]) begin
         dsub_hi_fix = dsub_hi[3:0] - 4'd6;
      end else begin
         dsub_hi_fix = dsub_hi[3:0];
      end
   end

   always_comb begin
      r = a;
      n = item.negative_in;
      z = item.zero_in;
      c_out = c;
      v = item.overflow_in;
      nz_from_r = 1'b1;
      case (item.op)
         OP_ADC: begin
            v = (a[7] ^ add_bin[7]) & (m[7] ^ add_bin[7]);
            if (item.decimal_mode) begin
               c_out = (dadd_hi > 6'd15);
               r = {dadd_hi[3:0], dadd_lo[3:0]};
            end else begin
               c_out = add_bin[8];
               r = add_bin[7:0];
            end
         end
         OP_SBC: begin
            v = (a[7] ^ m[7]) & (a[7] ^ sub_bin[7]);
            c_out = sub_bin[8];
            if (item.decimal_mode) begin
               r = {dsub_hi_fix, dsub_lo_fix};
            end else begin
               r = sub_bin[7:0];
            end
         end
         OP_AND: r = a & m;
         OP_ORA: r = a | m;
         OP_EOR: r = a ^ m;
         OP_ASL: begin
            c_out = a[7];
            r = {a[6:0], 1'b0};
         end
         OP_LSR: begin
            c_out = a[0];
            r = {1'b0, a[7:1]};
         end
         OP_ROL: begin
            c_out = a[7];
            r = {a[6:0], c};
         end
         OP_ROR: begin
            c_out = a[0];
            r = {c, a[7:1]};
         end
         OP_INC: r = a + 8'd1;
         OP_DEC: r = a - 8'd1;
         OP_CMP: begin
            nz_from_r = 1'b0;
            c_out = (a >= m);
            z = (a == m);
            n = cmp_diff[7];
         end
         OP_BIT: begin
            nz_from_r = 1'b0;
            z = ((a & m) == 8'd0);
            n = m[7];
            v = m[6];
         end
         OP_LOAD_FLAGS: r = m;
         OP_LOAD_NOFLAGS: begin
            r = m;
            nz_from_r = 1'b0;
         end
         default: nz_from_r = 1'b0;
      endcase
      if (nz_from_r) begin
         n = r[7];
         z = (r == 8'd0);
      end
   end

   assign res.result = r;
   assign res.negative_out = n;
   assign res.zero_out = z;
   assign res.carry_out = c_out;
   assign res.overflow_out = v;

endmodule

FILE: rtl/core/eight_bit_alu_with_bcd_flags_unit.sv
// eight-bit alu with bcd add and subtract: input register, datapath, result register
//
// usage
// - request channel req_*: one operation per beat with operands and incoming flags
// - response channel rsp_*: one beat per request, in order, with result and new flags
// - a beat moves at a rising edge with valid high and stall low
// - an accepted request goes through the input register, then the result register, which drives rsp_*
// - throughput: one beat per cycle while rsp_stall is low, set by the two-register
//   pipeline (input register, single-pass datapath, result register)
// - req_stall rises only when the input register holds a beat and the result
//   register is full and stalled; the input register keeps taking beats while
//   a finished result waits as long as the input register is empty
// - while rsp_stall is high the response beat holds its value unchanged
// - reset (synchronous, active high) empties both registers; no beat is lost
//   or repeated across a stall
module eight_bit_alu_with_bcd_flags_unit
   import eba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_op,
   input  logic [7:0] req_reg_operand,
   input  logic [7:0] req_mem_operand,
   input  logic       req_carry_in,
   input  logic       req_overflow_in,
   input  logic       req_negative_in,
   input  logic       req_zero_in,
   input  logic       req_decimal_mode,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_result,
   output logic       rsp_negative_out,
   output logic       rsp_zero_out,
   output logic       rsp_carry_out,
   output logic       rsp_overflow_out
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   req_item_type in_item_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   rsp_item_type alu_res;
   logic         out_open;
   logic         in_move;
   logic         req_take;

   assign out_open = ~out_valid_ff | ~rsp_stall;
   assign in_move = in_valid_ff & out_open;
   assign req_stall = in_valid_ff & ~out_open;
   assign req_take = req_valid & ~req_stall;

   always_comb begin
      in_item_in.op = req_op;
      in_item_in.reg_operand = req_reg_operand;
      in_item_in.mem_operand = req_mem_operand;
      in_item_in.carry_in = req_carry_in;
      in_item_in.overflow_in = req_overflow_in;
      in_item_in.negative_in = req_negative_in;
      in_item_in.zero_in = req_zero_in;
      in_item_in.decimal_mode = req_decimal_mode;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   assign out_valid_in = out_open ? in_valid_ff : out_valid_ff;
   assign out_item_in = alu_res;

   eba_alu u_alu (
      .item (in_item_ff),
      .res  (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      if (in_move) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result = out_item_ff.result;
   assign rsp_negative_out = out_item_ff.negative_out;
   assign rsp_zero_out = out_item_ff.zero_out;
   assign rsp_carry_out = out_item_ff.carry_out;
   assign rsp_overflow_out = out_item_ff.overflow_out;

`ifndef SYNTH
   // stall only with a beat waiting in the input register
   a_stall_needs_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input register");

   // an accepted beat occupies the input register next cycle
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted beat not held in input register");

   // a beat moving on from the input register appears on the response side
   a_move_offers: assert property (@(posedge clock) disable iff (reset)
      in_move |=> rsp_valid)
      else $error("beat lost between input and result registers");
`endif

endmodule

FILE: tb/eba_outcome_checker.sv
`timescale 1ns / 100ps
// watches both channels of the eight-bit alu, predicts each result beat and compares it
module eba_outcome_checker
   import eba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [3:0] req_op,
   input  logic [7:0] req_reg_operand,
   input  logic [7:0] req_mem_operand,
   input  logic       req_carry_in,
   input  logic       req_overflow_in,
   input  logic       req_negative_in,
   input  logic       req_zero_in,
   input  logic       req_decimal_mode,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_result,
   input  logic       rsp_negative_out,
   input  logic       rsp_zero_out,
   input  logic       rsp_carry_out,
   input  logic       rsp_overflow_out,
   output int         mismatch_count,
   output int         outstanding
);

   rsp_item_type expected_outcomes[$];

   function automatic rsp_item_type alu_outcome(input req_item_type beat);
      rsp_item_type outcome;
      logic [7:0]   a;
      logic [7:0]   m;
      logic [7:0]   r;
      logic [7:0]   gap;
      logic [8:0]   sum;
      logic [8:0]   diff;
      logic [5:0]   lo;
      logic [5:0]   hi;
      logic         c;
      logic         v;
      logic         n;
      logic         z;
      logic         nz_from_r;
      a = beat.reg_operand;
      m = beat.mem_operand;
      c = beat.carry_in;
      v = beat.overflow_in;
      n = beat.negative_in;
      z = beat.zero_in;
      r = a;
      nz_from_r = 1'b1;
      case (beat.op)
         OP_ADC: begin
            sum = {1'b0, a} + {1'b0, m} + {8'b0, c};
            v = ((a ^ sum[7:0]) & (m ^ sum[7:0]) & 8'h80) != 8'h00;
            if (beat.decimal_mode) begin
               lo = {2'b0, a[3:0]} + {2'b0, m[3:0]} + {5'b0, c};
               if (lo > 6'd9) lo = lo + 6'd6;
               hi = {2'b0, a[7:4]} + {2'b0, m[7:4]} + {5'b0, (lo > 6'd15)};
               if (hi > 6'd9) hi = hi + 6'd6;
               c = hi > 6'd15;
               r = {hi[3:0], lo[3:0]};
            end else begin
               c = sum[8];
               r = sum[7:0];
            end
         end
         OP_SBC: begin
            diff = {1'b1, a} - {1'b0, m} - {8'b0, ~c};
            v = ((a ^ m) & (a ^ diff[7:0]) & 8'h80) != 8'h00;
            if (beat.decimal_mode) begin
               lo = {2'b01, a[3:0]} - {2'b0, m[3:0]} - {5'b0, ~c};
               hi = {2'b01, a[7:4]} - {2'b0, m[7:4]};
               if (lo < 6'h10) begin
                  lo = lo - 6'd6;
                  hi = hi - 6'd1;
               end
               if (hi < 6'h10) hi = hi - 6'd6;
               r = {hi[3:0], lo[3:0]};
            end else begin
               r = diff[7:0];
            end
            c = diff[8];
         end
         OP_AND: r = a & m;
         OP_ORA: r = a | m;
         OP_EOR: r = a ^ m;
         OP_ASL: begin
            c = a[7];
            r = {a[6:0], 1'b0};
         end
         OP_LSR: begin
            c = a[0];
            r = {1'b0, a[7:1]};
         end
         OP_ROL: begin
            r = {a[6:0], c};
            c = a[7];
         end
         OP_ROR: begin
            r = {c, a[7:1]};
            c = a[0];
         end
         OP_INC: r = a + 8'd1;
         OP_DEC: r = a - 8'd1;
         OP_CMP: begin
            nz_from_r = 1'b0;
            gap = a - m;
            c = a >= m;
            z = a == m;
            n = gap[7];
         end
         OP_BIT: begin
            nz_from_r = 1'b0;
            z = (a & m) == 8'h00;
            n = m[7];
            v = m[6];
         end
         OP_LOAD_FLAGS: r = m;
         OP_LOAD_NOFLAGS: begin
            r = m;
            nz_from_r = 1'b0;
         end
         default: nz_from_r = 1'b0;
      endcase
      if (nz_from_r) begin
         n = r[7];
         z = r == 8'h00;
      end
      outcome.result = r;
      outcome.negative_out = n;
      outcome.zero_out = z;
      outcome.carry_out = c;
      outcome.overflow_out = v;
      return outcome;
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin : watch
      req_item_type taken;
      rsp_item_type want;
      rsp_item_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.result = rsp_result;
            got.negative_out = rsp_negative_out;
            got.zero_out = rsp_zero_out;
            got.carry_out = rsp_carry_out;
            got.overflow_out = rsp_overflow_out;
            if (expected_outcomes.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("%0t: result beat with nothing expected: result %h nzcv %b%b%b%b",
                           $realtime, got.result, got.negative_out, got.zero_out,
                           got.carry_out, got.overflow_out);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.result !== want.result || got.negative_out !== want.negative_out ||
                   got.zero_out !== want.zero_out || got.carry_out !== want.carry_out ||
                   got.overflow_out !== want.overflow_out) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch: expected result %h nzcv %b%b%b%b, got %h %b%b%b%b",
                              $realtime, want.result, want.negative_out, want.zero_out,
                              want.carry_out, want.overflow_out, got.result,
                              got.negative_out, got.zero_out, got.carry_out,
                              got.overflow_out);
               end
            end
         end
         if (req_valid && !req_stall) begin
            taken.op = req_op;
            taken.reg_operand = req_reg_operand;
            taken.mem_operand = req_mem_operand;
            taken.carry_in = req_carry_in;
            taken.overflow_in = req_overflow_in;
            taken.negative_in = req_negative_in;
            taken.zero_in = req_zero_in;
            taken.decimal_mode = req_decimal_mode;
            expected_outcomes.push_back(alu_outcome(taken));
         end
         outstanding <= expected_outcomes.size();
      end
   end

endmodule

FILE: tb/eight_bit_alu_with_bcd_flags_unit_test.sv
`timescale 1ns / 100ps
// stimulus, handshake pressure and verdict for the eight-bit alu with bcd flags
module eight_bit_alu_with_bcd_flags_unit_test
   import eba_pkg::*;
();

   localparam logic [3:0] OP_UNUSED = 4'd15;
   localparam int RANDOM_OPS = 450;
   localparam int HOLD_CYCLES = 80;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [3:0] req_op = OP_ADC;
   logic [7:0] req_reg_operand = 8'h00;
   logic [7:0] req_mem_operand = 8'h00;
   logic       req_carry_in = 1'b0;
   logic       req_overflow_in = 1'b0;
   logic       req_negative_in = 1'b0;
   logic       req_zero_in = 1'b0;
   logic       req_decimal_mode = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_result;
   logic       rsp_negative_out;
   logic       rsp_zero_out;
   logic       rsp_carry_out;
   logic       rsp_overflow_out;
   int         mismatch_count;
   int         outstanding;
   logic       calm_stretch = 1'b0;
   int         hold_requests = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   eight_bit_alu_with_bcd_flags_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_reg_operand  (req_reg_operand),
      .req_mem_operand  (req_mem_operand),
      .req_carry_in     (req_carry_in),
      .req_overflow_in  (req_overflow_in),
      .req_negative_in  (req_negative_in),
      .req_zero_in      (req_zero_in),
      .req_decimal_mode (req_decimal_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .rsp_negative_out (rsp_negative_out),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_carry_out    (rsp_carry_out),
      .rsp_overflow_out (rsp_overflow_out)
   );

   eba_outcome_checker outcome_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_reg_operand  (req_reg_operand),
      .req_mem_operand  (req_mem_operand),
      .req_carry_in     (req_carry_in),
      .req_overflow_in  (req_overflow_in),
      .req_negative_in  (req_negative_in),
      .req_zero_in      (req_zero_in),
      .req_decimal_mode (req_decimal_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .rsp_negative_out (rsp_negative_out),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_carry_out    (rsp_carry_out),
      .rsp_overflow_out (rsp_overflow_out),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   // called right after a rising edge; returns at the edge that takes the beat
   task automatic send_op(input logic [3:0] op, input logic [7:0] reg_operand,
                          input logic [7:0] mem_operand, input logic carry,
                          input logic overflow, input logic negative, input logic zero,
                          input logic decimal);
      if (!calm_stretch && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_reg_operand <= reg_operand;
      req_mem_operand <= mem_operand;
      req_carry_in <= carry;
      req_overflow_in <= overflow;
      req_negative_in <= negative;
      req_zero_in <= zero;
      req_decimal_mode <= decimal;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] corners[5];
      int         sel;
      corners = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h01};
      sel = $urandom_range(99);
      if (sel < 20) return corners[$urandom_range(4)];
      if (sel < 50) return {4'($urandom_range(9)), 4'($urandom_range(9))};
      return 8'($urandom);
   endfunction

   // response side: random stall, calm stretches and long hold-offs on request
   initial begin : receiver
      int holds_done;
      holds_done = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (holds_done < hold_requests) begin
            holds_done = holds_done + 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !calm_stretch && ($urandom_range(99) < 23);
            @(posedge clock);
         end
      end
   end

   initial begin
      #200000;
      $display("eight_bit_alu_with_bcd_flags_unit_test: done, errors");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_op(OP_ADC, 8'hff, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_op(OP_ADC, 8'h7f, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
      send_op(OP_ADC, 8'h99, 8'h01, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_op(OP_ADC, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_op(OP_ADC, 8'h58, 8'h46, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      send_op(OP_SBC, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_op(OP_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_op(OP_SBC, 8'h00, 8'h01, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_op(OP_SBC, 8'h50, 8'h25, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      send_op(OP_SBC, 8'h00, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      send_op(OP_AND, 8'hf0, 8'h0f, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
      send_op(OP_ORA, 8'h80, 8'h01, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      send_op(OP_EOR, 8'hff, 8'hff, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      send_op(OP_ASL, 8'h80, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_op(OP_LSR, 8'h01, 8'hff, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      send_op(OP_ROL, 8'h80, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      send_op(OP_ROR, 8'h01, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_op(OP_INC, 8'hff, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      send_op(OP_DEC, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
      send_op(OP_CMP, 8'h42, 8'h42, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      send_op(OP_CMP, 8'h01, 8'h80, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      send_op(OP_BIT, 8'h3f, 8'hc0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_op(OP_LOAD_FLAGS, 8'h55, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      send_op(OP_LOAD_NOFLAGS, 8'h00, 8'h80, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
      send_op(OP_UNUSED, 8'haa, 8'h55, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);

      // outstanding is registered, so it is read after the next edge, when it includes the beat just taken
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);

      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i == 150) calm_stretch <= 1'b1;
         if (i == 250) calm_stretch <= 1'b0;
         if (i == 300) hold_requests <= hold_requests + 1;
         if (i == 380) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (outstanding == 0);
            @(posedge clock);
         end
         send_op(4'($urandom_range(15)), pick_byte(), pick_byte(), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("eight_bit_alu_with_bcd_flags_unit_test: done, clean");
      else
         $display("eight_bit_alu_with_bcd_flags_unit_test: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/eba_pkg.sv
rtl/core/eba_alu.sv
rtl/core/eight_bit_alu_with_bcd_flags_unit.sv
tb/eba_outcome_checker.sv
tb/eight_bit_alu_with_bcd_flags_unit_test.sv
